/* hdl/bsat_pkg.sv */
// Shared constants for the Bezier split block.
`timescale 1ns / 1ps

package bsat_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam int IDX_W = 3;

  // command codes
  localparam logic CMD_QUAD  = 1'b0;
  localparam logic CMD_CUBIC = 1'b1;

  // index of the final point of each sequence
  localparam logic [IDX_W-1:0] LAST_QUAD  = 3'd4;
  localparam logic [IDX_W-1:0] LAST_CUBIC = 3'd6;

endpackage

/* hdl/bsat_if.sv */
// Valid/ready channel interfaces for segment input and point output.
`timescale 1ns / 1ps

interface bsat_in_if #(
  parameter int COORD_WIDTH = bsat_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = bsat_pkg::T_FRAC_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [COORD_WIDTH-1:0] p0_x;
  logic signed [COORD_WIDTH-1:0] p0_y;
  logic signed [COORD_WIDTH-1:0] p1_x;
  logic signed [COORD_WIDTH-1:0] p1_y;
  logic signed [COORD_WIDTH-1:0] p2_x;
  logic signed [COORD_WIDTH-1:0] p2_y;
  logic signed [COORD_WIDTH-1:0] p3_x;
  logic signed [COORD_WIDTH-1:0] p3_y;
  logic        [T_FRAC_BITS:0]   split_t;

  modport source (
    output valid, command, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, split_t,
    input  ready
  );
  modport sink (
    input  valid, command, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, split_t,
    output ready
  );
endinterface

interface bsat_out_if #(
  parameter int COORD_WIDTH = bsat_pkg::COORD_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic signed [COORD_WIDTH-1:0]   point_x;
  logic signed [COORD_WIDTH-1:0]   point_y;
  logic [bsat_pkg::IDX_W-1:0]      point_index;
  logic                            last;

  modport source (
    output valid, point_x, point_y, point_index, last,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_index, last,
    output ready
  );
endinterface

/* hdl/bezier_subdivide_at_t.sv */
// Top level: de Casteljau split of a quadratic or cubic Bezier segment at t.
// Path from an accepted segment to its first point: input register, three
//   interpolation levels of two stages each, merge register.
// Throughput: one point per cycle while pts.ready is high; a segment yields 5 (quadratic)
//   or 7 (cubic) points, so the point channel sets the sustained rate.
// Reset: rst clears the stage valid bits and the merge stage; datapath is not reset.
`timescale 1ns / 1ps

module bezier_subdivide_at_t #(
  parameter int COORD_WIDTH = bsat_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = bsat_pkg::T_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bsat_in_if.sink     seg,
  bsat_out_if.source  pts
);

  localparam int CW = COORD_WIDTH;
  localparam int PW = 2 * COORD_WIDTH;   // point = {y, x}
  localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  // Whole pipe moves together; it stalls only when the last stage holds a
  // segment that the merge stage cannot take yet.
  logic       en;
  logic       take;
  logic [6:0] vld;

  assign en        = !vld[6] || take;
  assign seg.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], seg.valid};
    end
  end

  // Stage 0: input register, t above one saturates to one.
  logic [PW-1:0]          b_q;
  logic [PW-1:0]          a_q   [0:6];
  logic [PW-1:0]          c_q   [0:6];
  logic [PW-1:0]          d_q   [0:6];
  logic                   cmd_q [0:6];
  logic [T_FRAC_BITS:0]   t_q   [0:4];
  logic [T_FRAC_BITS:0]   t_in;

  assign t_in = (seg.split_t[T_FRAC_BITS] && |seg.split_t[T_FRAC_BITS-1:0]) ?
                T_ONE : seg.split_t;

  // Lane outputs: each lerp's result register is the stage named.
  logic [PW-1:0] ab_w, bc_w, cd_w;     // stage 2
  logic [PW-1:0] abc_w, bcd_w;         // stage 4
  logic [PW-1:0] abcd_w;               // stage 6

  logic [PW-1:0] ab_q  [3:6];
  logic [PW-1:0] bc_q  [3:6];
  logic [PW-1:0] cd_q  [3:6];
  logic [PW-1:0] abc_q [5:6];
  logic [PW-1:0] bcd_q [5:6];

  always_ff @(posedge clk) begin
    if (en) begin
      a_q[0]   <= {seg.p0_y, seg.p0_x};
      b_q      <= {seg.p1_y, seg.p1_x};
      c_q[0]   <= {seg.p2_y, seg.p2_x};
      d_q[0]   <= {seg.p3_y, seg.p3_x};
      cmd_q[0] <= seg.command;
      t_q[0]   <= t_in;
      for (int k = 1; k <= 6; k++) begin
        a_q[k]   <= a_q[k-1];
        c_q[k]   <= c_q[k-1];
        d_q[k]   <= d_q[k-1];
        cmd_q[k] <= cmd_q[k-1];
      end
      for (int k = 1; k <= 4; k++) begin
        t_q[k] <= t_q[k-1];
      end
      ab_q[3] <= ab_w;
      bc_q[3] <= bc_w;
      cd_q[3] <= cd_w;
      for (int k = 4; k <= 6; k++) begin
        ab_q[k] <= ab_q[k-1];
        bc_q[k] <= bc_q[k-1];
        cd_q[k] <= cd_q[k-1];
      end
      abc_q[5] <= abc_w;
      bcd_q[5] <= bcd_w;
      abc_q[6] <= abc_q[5];
      bcd_q[6] <= bcd_q[5];
    end
  end

  // Interpolation lanes, one per coordinate of each point pair.
  for (genvar g = 0; g < 2; g++) begin : g_coord
    // level 1: stages 1-2
    bsat_lerp #(.COORD_WIDTH(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_ab (
      .clk(clk), .en(en), .p(a_q[0][g*CW +: CW]), .q(b_q[g*CW +: CW]),
      .t(t_q[0]), .r(ab_w[g*CW +: CW])
    );
    bsat_lerp #(.COORD_WIDTH(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_bc (
      .clk(clk), .en(en), .p(b_q[g*CW +: CW]), .q(c_q[0][g*CW +: CW]),
      .t(t_q[0]), .r(bc_w[g*CW +: CW])
    );
    bsat_lerp #(.COORD_WIDTH(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_cd (
      .clk(clk), .en(en), .p(c_q[0][g*CW +: CW]), .q(d_q[0][g*CW +: CW]),
      .t(t_q[0]), .r(cd_w[g*CW +: CW])
    );
    // level 2: stages 3-4
    bsat_lerp #(.COORD_WIDTH(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_abc (
      .clk(clk), .en(en), .p(ab_w[g*CW +: CW]), .q(bc_w[g*CW +: CW]),
      .t(t_q[2]), .r(abc_w[g*CW +: CW])
    );
    bsat_lerp #(.COORD_WIDTH(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_bcd (
      .clk(clk), .en(en), .p(bc_w[g*CW +: CW]), .q(cd_w[g*CW +: CW]),
      .t(t_q[2]), .r(bcd_w[g*CW +: CW])
    );
    // level 3: stages 5-6
    bsat_lerp #(.COORD_WIDTH(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_abcd (
      .clk(clk), .en(en), .p(abc_w[g*CW +: CW]), .q(bcd_w[g*CW +: CW]),
      .t(t_q[4]), .r(abcd_w[g*CW +: CW])
    );
  end

  // Merge: choose the sequence for the command and serialize it.
  bsat_merge #(.COORD_WIDTH(CW)) u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[6]),
    .take     (take),
    .cmd      (cmd_q[6]),
    .a        (a_q[6]),
    .ab       (ab_q[6]),
    .abc      (abc_q[6]),
    .abcd     (abcd_w),
    .bcd      (bcd_q[6]),
    .cd       (cd_q[6]),
    .d        (d_q[6]),
    .bc       (bc_q[6]),
    .c        (c_q[6]),
    .pts      (pts)
  );

endmodule

/* hdl/bsat_lerp.sv */
// One interpolation lane: r = p + floor((q - p) * t / 2^T_FRAC_BITS), two stages.
`timescale 1ns / 1ps

module bsat_lerp #(
  parameter int COORD_WIDTH = bsat_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = bsat_pkg::T_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [COORD_WIDTH-1:0] p,
  input  logic [COORD_WIDTH-1:0] q,
  input  logic [T_FRAC_BITS:0]   t,
  output logic [COORD_WIDTH-1:0] r
);

  localparam int PRW = COORD_WIDTH + T_FRAC_BITS + 3;

  logic signed [COORD_WIDTH:0]   diff;
  logic signed [T_FRAC_BITS+1:0] t_s;
  logic signed [PRW-1:0]         prod;
  logic signed [PRW-1:0]         prod1;
  logic        [COORD_WIDTH-1:0] p1;

  assign diff = $signed({q[COORD_WIDTH-1], q}) - $signed({p[COORD_WIDTH-1], p});
  assign t_s  = $signed({1'b0, t});
  assign prod = diff * t_s;

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= prod;
      p1    <= p;
      // arithmetic shift is the floor; the sum stays in range since t <= 1
      r     <= p1 + prod1[T_FRAC_BITS +: COORD_WIDTH];
    end
  end

endmodule

/* hdl/bsat_merge.sv */
// Merge stage: picks the point sequence for the command and sends one point per beat.
`timescale 1ns / 1ps

module bsat_merge #(
  parameter int COORD_WIDTH = bsat_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     take,
  input  logic                     cmd,
  input  logic [2*COORD_WIDTH-1:0] a,
  input  logic [2*COORD_WIDTH-1:0] ab,
  input  logic [2*COORD_WIDTH-1:0] abc,
  input  logic [2*COORD_WIDTH-1:0] abcd,
  input  logic [2*COORD_WIDTH-1:0] bcd,
  input  logic [2*COORD_WIDTH-1:0] cd,
  input  logic [2*COORD_WIDTH-1:0] d,
  input  logic [2*COORD_WIDTH-1:0] bc,
  input  logic [2*COORD_WIDTH-1:0] c,
  bsat_out_if.source               pts
);

  localparam int PW = 2 * COORD_WIDTH;

  logic [PW-1:0]                   seq [0:6];
  logic                            busy;
  logic [bsat_pkg::IDX_W-1:0]      idx;
  logic [bsat_pkg::IDX_W-1:0]      last_idx;
  logic                            is_last;
  logic                            cubic;

  assign cubic   = (cmd == bsat_pkg::CMD_CUBIC);
  assign is_last = (idx == last_idx);
  assign take    = !busy || (pts.ready && is_last);

  assign pts.valid       = busy;
  assign pts.point_x     = seq[0][COORD_WIDTH-1:0];
  assign pts.point_y     = seq[0][PW-1:COORD_WIDTH];
  assign pts.point_index = idx;
  assign pts.last        = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (take) begin
      busy <= in_valid;
      idx  <= '0;
    end else if (pts.ready) begin
      idx  <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      seq[0]   <= a;
      seq[1]   <= ab;
      seq[2]   <= abc;
      seq[3]   <= cubic ? abcd : bc;
      seq[4]   <= cubic ? bcd : c;
      seq[5]   <= cd;
      seq[6]   <= d;
      last_idx <= cubic ? bsat_pkg::LAST_CUBIC : bsat_pkg::LAST_QUAD;
    end else if (pts.ready) begin
      for (int k = 0; k < 6; k++) begin
        seq[k] <= seq[k+1];
      end
    end
  end

endmodule

/* dv/bsat_split_checker.sv */
// Checker for the Bezier split block: predicts each point stream and compares it beat by beat.
`timescale 1ns / 1ps

module bsat_split_checker #(
  parameter int COORD_WIDTH = bsat_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = bsat_pkg::T_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  bsat_in_if   seg,
  bsat_out_if  pts,
  output int   fail_count,
  output int   pending
);

  localparam int MAX_REPORTS = 10;
  localparam int IDX_W       = bsat_pkg::IDX_W;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [T_FRAC_BITS:0]          tpar_t;

  typedef struct {
    coord_t x;
    coord_t y;
  } xy_t;

  typedef struct {
    coord_t           x;
    coord_t           y;
    logic [IDX_W-1:0] index;
    logic             last;
  } point_t;

  point_t points_due[$];
  int     mismatches = 0;

  // p + floor((q - p) * t / 2^T_FRAC_BITS), exact product, floor by arithmetic shift
  function automatic coord_t lerp_coord(coord_t p, coord_t q, longint t);
    longint span;
    span = longint'(p);
    span = longint'(q) - span;
    return coord_t'(longint'(p) + ((span * t) >>> T_FRAC_BITS));
  endfunction

  function automatic xy_t lerp_xy(xy_t p, xy_t q, longint t);
    xy_t r;
    r.x = lerp_coord(p.x, q.x, t);
    r.y = lerp_coord(p.y, q.y, t);
    return r;
  endfunction

  // Splits one segment and queues its points in output order.
  function automatic void split_segment(logic cmd, xy_t a, xy_t b, xy_t c, xy_t d,
                                        tpar_t t_raw);
    longint           t;
    xy_t              ab, bc, cd, abc, bcd, abcd;
    xy_t              seq[7];
    int               n;
    logic [IDX_W-1:0] last_idx;
    point_t           pt;
    t = longint'(t_raw);
    // saturate to 1.0
    if (t > (longint'(1) << T_FRAC_BITS)) t = longint'(1) << T_FRAC_BITS;
    ab  = lerp_xy(a, b, t);
    bc  = lerp_xy(b, c, t);
    abc = lerp_xy(ab, bc, t);
    if (cmd == bsat_pkg::CMD_CUBIC) begin
      cd   = lerp_xy(c, d, t);
      bcd  = lerp_xy(bc, cd, t);
      abcd = lerp_xy(abc, bcd, t);
      seq[0] = a;    seq[1] = ab;  seq[2] = abc; seq[3] = abcd;
      seq[4] = bcd;  seq[5] = cd;  seq[6] = d;
      last_idx = bsat_pkg::LAST_CUBIC;
    end else begin
      seq[0] = a; seq[1] = ab; seq[2] = abc; seq[3] = bc; seq[4] = c;
      last_idx = bsat_pkg::LAST_QUAD;
    end
    n = int'(last_idx) + 1;
    for (int k = 0; k < n; k++) begin
      pt.x     = seq[k].x;
      pt.y     = seq[k].y;
      pt.index = IDX_W'(k);
      pt.last  = (IDX_W'(k) == last_idx);
      points_due = {points_due, pt};
    end
  endfunction

  always @(posedge clk) begin
    xy_t    a, b, c, d;
    point_t want;
    if (!rst) begin
      if (seg.valid && seg.ready) begin
        a.x = seg.p0_x; a.y = seg.p0_y;
        b.x = seg.p1_x; b.y = seg.p1_y;
        c.x = seg.p2_x; c.y = seg.p2_y;
        d.x = seg.p3_x; d.y = seg.p3_y;
        split_segment(seg.command, a, b, c, d, seg.split_t);
      end
      if (pts.valid && pts.ready) begin
        if (points_due.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected point beat: x=%0d y=%0d idx=%0d last=%0b",
                     pts.point_x, pts.point_y, pts.point_index, pts.last);
          mismatches++;
        end else begin
          want = points_due.pop_front();
          if (pts.point_x !== want.x || pts.point_y !== want.y ||
              pts.point_index !== want.index || pts.last !== want.last) begin
            if (mismatches < MAX_REPORTS)
              $display("point mismatch: exp x=%0d y=%0d idx=%0d last=%0b,",
                       want.x, want.y, want.index, want.last,
                       " got x=%0d y=%0d idx=%0d last=%0b",
                       pts.point_x, pts.point_y, pts.point_index, pts.last);
            mismatches++;
          end
        end
      end
    end
    pending    <= points_due.size();
    fail_count <= mismatches;
  end

endmodule

/* dv/tb.sv */
// Testbench top for the Bezier split block: clock, reset, segment stimulus, point backpressure.
`timescale 1ns / 1ps

module tb;

  localparam int     CW          = bsat_pkg::COORD_WIDTH_DEF;
  localparam int     TF          = bsat_pkg::T_FRAC_BITS_DEF;
  localparam longint T_ONE       = longint'(1) << TF;   // 1.0 in Q1.TF
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     HOLD_CYCLES = 400;                  // long receiver hold-off
  localparam int     HOLD_AFTER  = 30;                   // segment beats before hold-off
  localparam int     TAIL_CYCLES = 20;                   // slack after the drain
  localparam int     RANDOM_SEGS = 190;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [TF:0]          tpar_t;

  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};

  logic clk;
  logic rst;

  int fail_count;
  int pending;
  int seg_beats   = 0;
  int calm_left   = 0;
  int cycle_count = 0;

  bsat_in_if  seg_if ();
  bsat_out_if pts_if ();

  bezier_subdivide_at_t dut (
    .clk (clk),
    .rst (rst),
    .seg (seg_if),
    .pts (pts_if)
  );

  bsat_split_checker chk (
    .clk        (clk),
    .rst        (rst),
    .seg        (seg_if),
    .pts        (pts_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost point ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Coordinates: mostly full-range random, with the extremes and small values
  // mixed in so both large spans and sign changes near zero show up.
  function automatic coord_t rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return C_MIN;
      1:       return C_MAX;
      2, 3:    return coord_t'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Split parameter: mostly inside [0, 1], sometimes the end points, sometimes
  // above 1.0 where the block has to saturate.
  function automatic tpar_t rand_t();
    int pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       return tpar_t'(0);
      1:       return tpar_t'(T_ONE);
      2, 3:    return tpar_t'($urandom_range(int'(T_ONE) + 1, 2 * int'(T_ONE) - 1));
      4:       return tpar_t'(2 * T_ONE - 1);
      default: return tpar_t'($urandom_range(0, int'(T_ONE)));
    endcase
  endfunction

  // Sender gap: mostly back to back or short, a few long, and now and then a
  // calm run of gapless beats.
  function automatic int pick_gap();
    int pick;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      calm_left = $urandom_range(20, 40);
      return 0;
    end
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one segment and holds it until the block takes the beat. valid stays
  // high across back-to-back beats, so it gets one assignment per edge.
  task automatic offer_segment(input logic cmd,
                               input coord_t x0, input coord_t y0,
                               input coord_t x1, input coord_t y1,
                               input coord_t x2, input coord_t y2,
                               input coord_t x3, input coord_t y3,
                               input tpar_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      seg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_if.valid   <= 1'b1;
    seg_if.command <= cmd;
    seg_if.p0_x    <= x0;
    seg_if.p0_y    <= y0;
    seg_if.p1_x    <= x1;
    seg_if.p1_y    <= y1;
    seg_if.p2_x    <= x2;
    seg_if.p2_y    <= y2;
    seg_if.p3_x    <= x3;
    seg_if.p3_y    <= y3;
    seg_if.split_t <= t;
    do @(posedge clk); while (!seg_if.ready);
    seg_beats++;
  endtask

  task automatic offer_random(input logic cmd);
    offer_segment(cmd, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_t());
  endtask

  // Point side: random stalls, mostly short; once the block has taken a few
  // dozen segments the receiver holds off long enough to back up the pipeline
  // while the sender keeps offering.
  initial begin
    bit held = 1'b0;
    int pick;
    pts_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && seg_beats >= HOLD_AFTER) begin
        held = 1'b1;
        pts_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          pts_if.ready <= 1'b1;
          repeat ($urandom_range(1, 40)) @(posedge clk);
        end else if (pick < 95) begin
          pts_if.ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          pts_if.ready <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end
      end
    end
  end

  // Segment side and verdict.
  initial begin
    rst            <= 1'b1;
    seg_if.valid   <= 1'b0;
    seg_if.command <= bsat_pkg::CMD_QUAD;
    seg_if.p0_x    <= '0;
    seg_if.p0_y    <= '0;
    seg_if.p1_x    <= '0;
    seg_if.p1_y    <= '0;
    seg_if.p2_x    <= '0;
    seg_if.p2_y    <= '0;
    seg_if.p3_x    <= '0;
    seg_if.p3_y    <= '0;
    seg_if.split_t <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero segment, t at 0 and 1.0, full-range spans both ways
    offer_segment(bsat_pkg::CMD_QUAD, '0, '0, '0, '0, '0, '0, '0, '0, tpar_t'(0));
    offer_segment(bsat_pkg::CMD_QUAD, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, '0, '0,
                  tpar_t'(T_ONE));
    offer_segment(bsat_pkg::CMD_CUBIC, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                  tpar_t'(0));
    offer_segment(bsat_pkg::CMD_CUBIC, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                  tpar_t'(T_ONE));
    offer_segment(bsat_pkg::CMD_CUBIC, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                  tpar_t'(T_ONE / 2));
    // smallest and largest fractional steps
    offer_segment(bsat_pkg::CMD_CUBIC, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX,
                  tpar_t'(1));
    offer_segment(bsat_pkg::CMD_CUBIC, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN,
                  tpar_t'(T_ONE - 1));
    // t above one must saturate to 1.0
    offer_segment(bsat_pkg::CMD_QUAD, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, '0, '0,
                  tpar_t'(T_ONE + 1));
    offer_segment(bsat_pkg::CMD_CUBIC, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                  tpar_t'(2 * T_ONE - 1));
    // quadratic with the fourth point at its extremes, which must be ignored
    offer_segment(bsat_pkg::CMD_QUAD, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), C_MIN, C_MAX, rand_t());
    offer_segment(bsat_pkg::CMD_QUAD, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), C_MAX, C_MIN, rand_t());
    // negative spans of one LSB: the shift must round toward minus infinity
    offer_segment(bsat_pkg::CMD_QUAD, '0, '0, -1, -1, -1, 1, '0, '0, tpar_t'(1));
    offer_segment(bsat_pkg::CMD_CUBIC, '0, '0, -1, 1, 1, -1, -1, 1, tpar_t'(T_ONE - 1));
    // flat segments at both ends of the range
    offer_segment(bsat_pkg::CMD_CUBIC, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                  tpar_t'(12345));
    offer_segment(bsat_pkg::CMD_QUAD, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                  tpar_t'(T_ONE - 1));
    for (int i = 0; i < 4; i++) offer_random(bsat_pkg::CMD_QUAD);
    for (int i = 0; i < 4; i++) offer_random(bsat_pkg::CMD_CUBIC);

    // random part: both shapes mixed, every field random
    for (int i = 0; i < RANDOM_SEGS; i++) offer_random(logic'($urandom_range(0, 1)));
    seg_if.valid <= 1'b0;

    // wait until the checker's count includes the last segment, then drain and let the
    // pipeline settle in case anything stray comes out
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
